// ===== rtl/core/vtd_pkg.sv =====
`default_nettype none
package vtd_pkg;

    localparam int DEF_NUM_TAGS = 16;
    localparam int DEF_MAX_LEN  = 64;
    localparam int SCORE_W      = 32;
    localparam int ACT_W        = 2;
    localparam int POS_FW       = 6;
    localparam int TAG_FW       = 4;

    localparam logic signed [SCORE_W-1:0] NEG_INF = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] POS_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] NEG_MIN = {1'b1, {(SCORE_W-2){1'b0}}, 1'b1};

    typedef enum logic [ACT_W-1:0] {
        ACT_TAG_SCORE = 2'd0,
        ACT_TRANS     = 2'd1,
        ACT_FINISH    = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TS_WR,
        ST_TR_CHK,
        ST_TR_RD2,
        ST_TR_SUM,
        ST_TR_WR,
        ST_FIN_CHK,
        ST_SCAN,
        ST_BP_RD,
        ST_OUT,
        ST_CLR
    } state_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] a;
        logic signed [SCORE_W-1:0] b;
        logic signed [SCORE_W-1:0] c;
        logic signed [SCORE_W-1:0] x1;
        logic signed [SCORE_W-1:0] y1;
        logic signed [SCORE_W-1:0] x2;
        logic signed [SCORE_W-1:0] y2;
    } unit_op_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] sum;
        logic                      gt1;
        logic                      gt2;
    } unit_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/vtd_if.sv =====
`default_nettype none
interface vtd_in_if;
    import vtd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [ACT_W-1:0]          action;
    logic [POS_FW-1:0]         position;
    logic [TAG_FW-1:0]         prev_tag;
    logic [TAG_FW-1:0]         tag;
    logic signed [SCORE_W-1:0] score;
    modport source (output valid, action, position, prev_tag, tag, score, input ready);
    modport sink (input valid, action, position, prev_tag, tag, score, output ready);
endinterface

interface vtd_out_if;
    import vtd_pkg::*;
    logic              valid;
    logic              ready;
    logic [POS_FW-1:0] out_position;
    logic [TAG_FW-1:0] out_tag;
    logic              last;
    modport source (output valid, out_position, out_tag, last, input ready);
    modport sink (input valid, out_position, out_tag, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/vtd_ram.sv =====
`default_nettype none
module vtd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/vtd_score_unit.sv =====
`default_nettype none
module vtd_score_unit (
    input  wire vtd_pkg::unit_op_t  op,
    output      vtd_pkg::unit_res_t res
);
    import vtd_pkg::*;

    logic signed [SCORE_W+1:0] wide;

    always_comb
    begin
        wide = (SCORE_W+2)'(op.a) + (SCORE_W+2)'(op.b) + (SCORE_W+2)'(op.c);
        if (wide > (SCORE_W+2)'(POS_MAX))
        begin
            res.sum = POS_MAX;
        end
        else if (wide < (SCORE_W+2)'(NEG_MIN))
        begin
            res.sum = NEG_MIN;
        end
        else
        begin
            res.sum = SCORE_W'(wide);
        end
        res.gt1 = op.x1 > op.y1;
        res.gt2 = op.x2 > op.y2;
    end
endmodule
`default_nettype wire

// ===== rtl/core/viterbi_tag_decoder.sv =====
`default_nettype none
// A tag score beat writes its cell once accepted; a transition beat passes check, read, sum and write states.
// A finish beat scans all tags of a column at the start and wherever a trace back has no
// predecessor, reads a back pointer for each emitted result beat (which waits on ready), and
// then clears one present map row per filled column before the next beat is accepted.
// Each memory has a single read port.
// Reset (asynchronous, active low) clears the column count, then the whole map is cleared row by row.
module viterbi_tag_decoder #(
    parameter int NUM_TAGS = vtd_pkg::DEF_NUM_TAGS,
    parameter int MAX_LEN  = vtd_pkg::DEF_MAX_LEN
) (
    input wire logic clk,
    input wire logic rst_n,
    vtd_in_if.sink   item_in,
    vtd_out_if.source result_out
);
    import vtd_pkg::*;

    localparam int CELLS = MAX_LEN * NUM_TAGS;
    localparam int IDX_W = $clog2(CELLS);
    localparam int POS_W = $clog2(MAX_LEN);
    localparam int TAG_W = $clog2(NUM_TAGS);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int BP_W  = TAG_W + 1;

    state_t state_reg, state_next;

    logic [ACT_W-1:0]          act_reg, act_next;
    logic [POS_FW-1:0]         pos_reg, pos_next;
    logic [TAG_FW-1:0]         prev_reg, prev_next;
    logic [TAG_FW-1:0]         tag_reg, tag_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic [CNT_W-1:0]          col_reg, col_next;
    logic signed [SCORE_W-1:0] gp_reg, gp_next;
    logic signed [SCORE_W-1:0] tsv_reg, tsv_next;
    logic signed [SCORE_W-1:0] gc_reg, gc_next;
    logic signed [SCORE_W-1:0] sum_reg, sum_next;
    logic                      skip_reg, skip_next;
    logic [POS_W-1:0]          scan_pos_reg, scan_pos_next;
    logic [TAG_W:0]            cnt_reg, cnt_next;
    logic                      dv_reg, dv_next;
    logic [TAG_W-1:0]          dtag_reg, dtag_next;
    logic                      found_reg, found_next;
    logic [TAG_W-1:0]          bg_reg, bg_next;
    logic signed [SCORE_W-1:0] bgv_reg, bgv_next;
    logic [TAG_W-1:0]          bs_reg, bs_next;
    logic signed [SCORE_W-1:0] bsv_reg, bsv_next;
    logic [POS_W-1:0]          i_reg, i_next;
    logic [TAG_W-1:0]          cur_reg, cur_next;
    logic [POS_W-1:0]          clr_reg, clr_next;

    logic                pm_we, pm_re;
    logic [POS_W-1:0]    pm_waddr, pm_raddr;
    logic [NUM_TAGS-1:0] pm_wdata, pm_rdata;

    logic             g_we, g_re, t_we, t_re, b_we, b_re;
    logic [IDX_W-1:0] g_waddr, g_raddr, t_waddr, t_raddr, b_waddr, b_raddr;
    logic signed [SCORE_W-1:0] g_wdata, g_rdata, t_wdata, t_rdata;
    logic [BP_W-1:0]  b_wdata, b_rdata;

    unit_op_t  uop;
    unit_res_t ures;

    logic [POS_W-1:0] p_idx, pm1_idx;
    logic [TAG_W-1:0] t_idx, pv_idx;
    logic             pos_ok, tag_ok, prev_ok, tr_ok;
    logic             scan_done;
    logic [TAG_W-1:0] scan_pick;

    function automatic logic [IDX_W-1:0] cell_addr(input logic [POS_W-1:0] p,
                                                  input logic [TAG_W-1:0] t);
        cell_addr = IDX_W'(int'(p) * NUM_TAGS + int'(t));
    endfunction

    vtd_ram #(.WIDTH(SCORE_W), .DEPTH(CELLS)) u_gain_ram (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
    );

    vtd_ram #(.WIDTH(SCORE_W), .DEPTH(CELLS)) u_tag_score_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
    );

    vtd_ram #(.WIDTH(BP_W), .DEPTH(CELLS)) u_bp_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
    );

    vtd_ram #(.WIDTH(NUM_TAGS), .DEPTH(MAX_LEN)) u_present_ram (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .re(pm_re), .raddr(pm_raddr), .rdata(pm_rdata)
    );

    vtd_score_unit u_unit (
        .op(uop),
        .res(ures)
    );

    assign p_idx   = POS_W'(pos_reg);
    assign pm1_idx = POS_W'(pos_reg) - POS_W'(1);
    assign t_idx   = TAG_W'(tag_reg);
    assign pv_idx  = TAG_W'(prev_reg);
    assign pos_ok  = 7'(pos_reg) < 7'(MAX_LEN);
    assign tag_ok  = 7'(tag_reg) < 7'(NUM_TAGS);
    assign prev_ok = 7'(prev_reg) < 7'(NUM_TAGS);
    assign tr_ok   = (pos_reg != '0) && pos_ok && tag_ok && prev_ok && pm_rdata[t_idx];
    assign scan_done = (cnt_reg == (TAG_W+1)'(NUM_TAGS)) && !dv_reg;
    assign scan_pick = !found_reg ? '0 : ((bgv_reg == NEG_INF) ? bs_reg : bg_reg);

    assign item_in.ready          = (state_reg == ST_IDLE);
    assign result_out.valid       = (state_reg == ST_OUT);
    assign result_out.out_position = POS_FW'(i_reg);
    assign result_out.out_tag     = TAG_FW'(cur_reg);
    assign result_out.last        = (i_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            col_reg   <= '0;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
            found_reg <= 1'b0;
            clr_reg   <= POS_W'(MAX_LEN - 1);
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            dv_reg    <= dv_next;
            found_reg <= found_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pos_reg      <= pos_next;
        prev_reg     <= prev_next;
        tag_reg      <= tag_next;
        score_reg    <= score_next;
        gp_reg       <= gp_next;
        tsv_reg      <= tsv_next;
        gc_reg       <= gc_next;
        sum_reg      <= sum_next;
        skip_reg     <= skip_next;
        scan_pos_reg <= scan_pos_next;
        dtag_reg     <= dtag_next;
        bg_reg       <= bg_next;
        bgv_reg      <= bgv_next;
        bs_reg       <= bs_next;
        bsv_reg      <= bsv_next;
        i_reg        <= i_next;
        cur_reg      <= cur_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        pos_next      = pos_reg;
        prev_next     = prev_reg;
        tag_next      = tag_reg;
        score_next    = score_reg;
        col_next      = col_reg;
        gp_next       = gp_reg;
        tsv_next      = tsv_reg;
        gc_next       = gc_reg;
        sum_next      = sum_reg;
        skip_next     = skip_reg;
        scan_pos_next = scan_pos_reg;
        cnt_next      = cnt_reg;
        dv_next       = dv_reg;
        dtag_next     = dtag_reg;
        found_next    = found_reg;
        bg_next       = bg_reg;
        bgv_next      = bgv_reg;
        bs_next       = bs_reg;
        bsv_next      = bsv_reg;
        i_next        = i_reg;
        cur_next      = cur_reg;
        clr_next      = clr_reg;
        pm_we         = 1'b0;
        pm_re         = 1'b0;
        pm_waddr      = clr_reg;
        pm_raddr      = p_idx;
        pm_wdata      = '0;
        g_we = 1'b0; g_re = 1'b0; t_we = 1'b0; t_re = 1'b0; b_we = 1'b0; b_re = 1'b0;
        g_waddr = cell_addr(p_idx, t_idx);
        t_waddr = cell_addr(p_idx, t_idx);
        b_waddr = cell_addr(p_idx, t_idx);
        g_raddr = cell_addr(p_idx, t_idx);
        t_raddr = cell_addr(p_idx, t_idx);
        b_raddr = cell_addr(i_reg, cur_reg);
        g_wdata = score_reg;
        t_wdata = score_reg;
        b_wdata = '0;
        uop.a  = gp_reg;
        uop.b  = tsv_reg;
        uop.c  = score_reg;
        uop.x1 = gc_reg;
        uop.y1 = sum_reg;
        uop.x2 = t_rdata;
        uop.y2 = bsv_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_in.valid)
                begin
                    pm_re      = 1'b1;
                    pm_raddr   = POS_W'(item_in.position);
                    act_next   = item_in.action;
                    pos_next   = item_in.position;
                    prev_next  = item_in.prev_tag;
                    tag_next   = item_in.tag;
                    score_next = item_in.score;
                    case (action_t'(item_in.action))
                        ACT_TAG_SCORE: state_next = ST_TS_WR;
                        ACT_TRANS:     state_next = ST_TR_CHK;
                        ACT_FINISH:    state_next = ST_FIN_CHK;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TS_WR:
            begin
                if (pos_ok && tag_ok)
                begin
                    pm_we    = 1'b1;
                    pm_waddr = p_idx;
                    pm_wdata = pm_rdata | (NUM_TAGS'(1) << t_idx);
                    t_we     = 1'b1;
                    g_we     = 1'b1;
                    b_we     = 1'b1;
                    g_wdata  = (pos_reg == '0) ? score_reg : NEG_INF;
                    if ((CNT_W'(p_idx) + CNT_W'(1)) > col_reg)
                    begin
                        col_next = CNT_W'(p_idx) + CNT_W'(1);
                    end
                end
                state_next = ST_IDLE;
            end
            ST_TR_CHK:
            begin
                if (tr_ok)
                begin
                    pm_re      = 1'b1;
                    pm_raddr   = pm1_idx;
                    g_re       = 1'b1;
                    t_re       = 1'b1;
                    g_raddr    = cell_addr(pm1_idx, pv_idx);
                    state_next = ST_TR_RD2;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TR_RD2:
            begin
                if (pm_rdata[pv_idx])
                begin
                    g_re       = 1'b1;
                    gp_next    = g_rdata;
                    tsv_next   = t_rdata;
                    state_next = ST_TR_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TR_SUM:
            begin
                gc_next    = g_rdata;
                sum_next   = ures.sum;
                skip_next  = (gp_reg == NEG_INF) || (tsv_reg == NEG_INF)
                             || (score_reg == NEG_INF);
                state_next = ST_TR_WR;
            end
            ST_TR_WR:
            begin
                if (!skip_reg && !ures.gt1)
                begin
                    g_we    = 1'b1;
                    b_we    = 1'b1;
                    g_wdata = sum_reg;
                    b_wdata = {1'b1, pv_idx};
                end
                state_next = ST_IDLE;
            end
            ST_FIN_CHK:
            begin
                if (col_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pm_re         = 1'b1;
                    pm_raddr      = POS_W'(col_reg - CNT_W'(1));
                    i_next        = POS_W'(col_reg - CNT_W'(1));
                    scan_pos_next = POS_W'(col_reg - CNT_W'(1));
                    cnt_next      = '0;
                    dv_next       = 1'b0;
                    found_next    = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                uop.x1 = g_rdata;
                uop.y1 = bgv_reg;
                if (cnt_reg != (TAG_W+1)'(NUM_TAGS))
                begin
                    g_re     = 1'b1;
                    t_re     = 1'b1;
                    g_raddr  = cell_addr(scan_pos_reg, TAG_W'(cnt_reg));
                    t_raddr  = cell_addr(scan_pos_reg, TAG_W'(cnt_reg));
                    cnt_next = cnt_reg + (TAG_W+1)'(1);
                    dtag_next = TAG_W'(cnt_reg);
                    dv_next  = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end
                if (dv_reg && pm_rdata[dtag_reg])
                begin
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        bg_next    = dtag_reg;
                        bgv_next   = g_rdata;
                        bs_next    = dtag_reg;
                        bsv_next   = t_rdata;
                    end
                    else
                    begin
                        if (ures.gt1)
                        begin
                            bg_next  = dtag_reg;
                            bgv_next = g_rdata;
                        end
                        if (ures.gt2)
                        begin
                            bs_next  = dtag_reg;
                            bsv_next = t_rdata;
                        end
                    end
                end
                if (scan_done)
                begin
                    cur_next   = scan_pick;
                    state_next = ST_BP_RD;
                end
            end
            ST_BP_RD:
            begin
                b_re       = 1'b1;
                pm_re      = 1'b1;
                pm_raddr   = i_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result_out.ready)
                begin
                    if (i_reg == '0)
                    begin
                        clr_next   = POS_W'(col_reg - CNT_W'(1));
                        col_next   = '0;
                        state_next = ST_CLR;
                    end
                    else if (pm_rdata[cur_reg] && b_rdata[BP_W-1])
                    begin
                        cur_next   = b_rdata[TAG_W-1:0];
                        i_next     = i_reg - POS_W'(1);
                        state_next = ST_BP_RD;
                    end
                    else
                    begin
                        pm_re         = 1'b1;
                        pm_raddr      = i_reg - POS_W'(1);
                        i_next        = i_reg - POS_W'(1);
                        scan_pos_next = i_reg - POS_W'(1);
                        cnt_next      = '0;
                        dv_next       = 1'b0;
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_CLR:
            begin
                pm_we = 1'b1;
                if (clr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg - POS_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> !item_in.ready)
        else $error("Result beat offered while input is open.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.ready && result_out.last) |=> (col_reg == '0))
        else $error("Column count not cleared after the final result beat.");

    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CNT_W'(MAX_LEN))
        else $error("Column count exceeds the sentence length limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (CNT_W'(i_reg) < col_reg))
        else $error("Trace back position outside the filled columns.");

endmodule
`default_nettype wire
